/* hw/rtl/obl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_pkg
// Shared constants and types for the order book level change meter.
// ----------------------------------------------------------------------------
package obl_pkg;

  // price levels per side of the book
  localparam int unsigned LEVELS    = 4096;
  localparam int unsigned IDX_W     = $clog2(LEVELS);
  // memory address: side bit over level index
  localparam int unsigned ADDR_W    = IDX_W + 1;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  // generation tag stored with each level; tag 0 marks an empty level
  localparam int unsigned EPOCH_W   = 8;

  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_INS_BID = 8'h02;
  localparam logic [7:0] CMD_INS_ASK = 8'h03;
  localparam logic [7:0] CMD_MOD_BID = 8'h04;
  localparam logic [7:0] CMD_MOD_ASK = 8'h05;
  localparam logic [7:0] CMD_DEL_BID = 8'h06;
  localparam logic [7:0] CMD_DEL_ASK = 8'h07;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CLEAR,
    KIND_SET,
    KIND_DEL
  } kind_e;

  // decoded request, produced at acceptance
  typedef struct packed {
    kind_e            kind;
    logic             is_ask;
    logic             in_win;
    logic [IDX_W-1:0] idx;
  } req_t;

  // one level entry in the book memory
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [31:0]        qty;
  } word_t;

endpackage

/* hw/rtl/obl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module obl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read-before-write on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/obl_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obl_decode
// Command decode and price-to-level window mapping.
// ----------------------------------------------------------------------------
module obl_decode (
  input  logic [7:0]    command_i,
  input  logic [31:0]   price_tick_i,
  input  logic [31:0]   base_tick_i,
  output obl_pkg::req_t req_o
);

  logic [32:0] off;

  // 33-bit signed difference, cannot overflow
  assign off = {price_tick_i[31], price_tick_i} - {base_tick_i[31], base_tick_i};

  always_comb begin
    req_o.kind   = obl_pkg::KIND_NONE;
    req_o.is_ask = command_i[0];  // odd codes are the ask side
    req_o.in_win = !off[32] && (off[31:0] < 32'(obl_pkg::LEVELS));
    req_o.idx    = off[obl_pkg::IDX_W-1:0];
    unique case (command_i) inside
      obl_pkg::CMD_CLEAR: begin
        req_o.kind = obl_pkg::KIND_CLEAR;
      end
      obl_pkg::CMD_INS_BID, obl_pkg::CMD_INS_ASK,
      obl_pkg::CMD_MOD_BID, obl_pkg::CMD_MOD_ASK: begin
        req_o.kind = obl_pkg::KIND_SET;
      end
      obl_pkg::CMD_DEL_BID, obl_pkg::CMD_DEL_ASK: begin
        req_o.kind = obl_pkg::KIND_DEL;
      end
      default: begin
        req_o.kind = obl_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

/* hw/rtl/order_book_level_change_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_level_change_meter
// Per-level market depth book with live quantity change measurement.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one depth request per handshake (command, end_of_batch,
//            price_tick, quantity). in_ready_o may drop; hold the request.
//   out_*  : one result per request, in order, from an output register.
//   cfg_*  : write of base_tick; always ready, apply only while idle.
// Pipeline: execute stage, then output register. Throughput: one request
//   per cycle unless a sweep, tag wrap or stall drops in_ready_o. The book
//   memory (one read and one write port) is read on acceptance and written
//   back from execute; a same-level request directly behind is served from
//   a bypass register. Clear bumps an 8-bit generation tag instead of
//   wiping the book. When the tag wraps (every 255th clear) the request
//   behind is held back and the memory is swept, one entry a cycle, over all
//   2 * LEVELS = 8192 entries. Reset: the same sweep runs; in_ready_o is
//   low throughout. Flags clear, base_tick returns to 0.
// Receiver stall: the output register holds its result; one further
//   request may be accepted and then waits in the execute stage.
// ----------------------------------------------------------------------------
module order_book_level_change_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_base_tick_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  command_i,
  input  logic        end_of_batch_i,
  input  logic [31:0] price_tick_i,
  input  logic [31:0] quantity_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] gross_change_o,
  output logic        counted_o,
  output logic        outside_window_o,
  output logic        book_ready_o
);

  localparam int unsigned AW = obl_pkg::ADDR_W;
  localparam int unsigned EW = obl_pkg::EPOCH_W;

  // configuration register
  logic [31:0] base_tick_q;

  // execute stage
  logic                   exe_valid_q;
  obl_pkg::kind_e         exe_kind_q;
  logic                   exe_in_win_q;
  logic                   exe_eob_q;
  logic [31:0]            exe_qty_q;
  logic [AW-1:0]          exe_addr_q;

  // bypass of the write-back that collided with this read
  logic                   byp_q;
  obl_pkg::word_t         byp_data_q;

  // book flags and generation tag
  logic                   snap_q, snap_d;
  logic                   valid_q, valid_d;
  logic [EW-1:0]          epoch_q;

  // memory sweep
  logic                   sweep_q;
  logic [AW-1:0]          sweep_cnt_q;

  // output register
  logic                   out_valid_q;
  logic [31:0]            gross_q;
  logic                   counted_q;
  logic                   outside_q;
  logic                   ready_q;

  obl_pkg::req_t          dec;
  logic [AW-1:0]          rd_addr;
  logic                   accept;
  logic                   exe_fire;
  logic                   wrap;
  logic                   exe_wr;
  obl_pkg::word_t         rd_word;
  obl_pkg::word_t         old_word;
  obl_pkg::word_t         new_word;
  logic [$bits(obl_pkg::word_t)-1:0] ram_rdata;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  obl_pkg::word_t         ram_wdata;
  logic [31:0]            old_qty;
  logic [31:0]            diff;
  logic [31:0]            gross;
  logic                   live;
  logic                   counted;

  obl_decode u_decode (
    .command_i    (command_i),
    .price_tick_i (price_tick_i),
    .base_tick_i  (base_tick_q),
    .req_o        (dec)
  );

  assign rd_addr = {dec.is_ask, dec.idx};

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign exe_fire    = exe_valid_q && (!out_valid_q || out_ready_i);
  // a clear that wraps the tag starts a sweep; hold back the next read
  assign wrap        = exe_valid_q && (exe_kind_q == obl_pkg::KIND_CLEAR) &&
                       (epoch_q == {EW{1'b1}});
  assign in_ready_o  = !sweep_q && !wrap && (!exe_valid_q || exe_fire);
  assign accept      = in_valid_i && in_ready_o;

  obl_ram #(
    .WIDTH ($bits(obl_pkg::word_t)),
    .DEPTH (obl_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign rd_word  = obl_pkg::word_t'(ram_rdata);
  assign old_word = byp_q ? byp_data_q : rd_word;
  // level present only if tagged with the current generation
  assign old_qty  = (old_word.epoch == epoch_q) ? old_word.qty : 32'd0;
  assign diff     = (old_qty >= exe_qty_q) ? (old_qty - exe_qty_q)
                                           : (exe_qty_q - old_qty);
  assign live     = !snap_q && valid_q;
  assign exe_wr   = exe_in_win_q &&
                    ((exe_kind_q == obl_pkg::KIND_SET) ||
                     (exe_kind_q == obl_pkg::KIND_DEL));

  always_comb begin
    new_word = '0;
    gross    = 32'd0;
    counted  = 1'b0;
    snap_d   = snap_q;
    valid_d  = valid_q;
    case (exe_kind_q)
      obl_pkg::KIND_CLEAR: begin
        snap_d  = !exe_eob_q;
        valid_d = exe_eob_q;
      end
      obl_pkg::KIND_SET, obl_pkg::KIND_DEL: begin
        if (exe_kind_q == obl_pkg::KIND_SET) begin
          new_word.epoch = epoch_q;
          new_word.qty   = exe_qty_q;
          gross          = diff;
        end else begin
          gross          = old_qty;  // deleted entry keeps tag 0
        end
        counted = live && exe_in_win_q;
        if (snap_q && exe_eob_q) begin
          snap_d  = 1'b0;
          valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // write port: sweep, else write-back
  always_comb begin
    if (sweep_q) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = exe_fire && exe_wr;
      ram_waddr = exe_addr_q;
      ram_wdata = new_word;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_tick_q <= 32'd0;
      exe_valid_q <= 1'b0;
      byp_q       <= 1'b0;
      snap_q      <= 1'b0;
      valid_q     <= 1'b0;
      epoch_q     <= {{(EW-1){1'b0}}, 1'b1};
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        base_tick_q <= cfg_base_tick_i;
      end

      if (accept) begin
        exe_valid_q <= 1'b1;
        byp_q       <= exe_fire && exe_wr && (exe_addr_q == rd_addr);
      end else if (exe_fire) begin
        exe_valid_q <= 1'b0;
      end

      if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + 1'b1;
        if (sweep_cnt_q == {AW{1'b1}}) begin
          sweep_q <= 1'b0;
        end
      end

      if (exe_fire) begin
        snap_q  <= snap_d;
        valid_q <= valid_d;
        if (exe_kind_q == obl_pkg::KIND_CLEAR) begin
          if (epoch_q == {EW{1'b1}}) begin
            epoch_q     <= {{(EW-1){1'b0}}, 1'b1};
            sweep_q     <= 1'b1;
            sweep_cnt_q <= '0;
          end else begin
            epoch_q <= epoch_q + 1'b1;
          end
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      exe_kind_q   <= dec.kind;
      exe_in_win_q <= dec.in_win;
      exe_eob_q    <= end_of_batch_i;
      exe_qty_q    <= quantity_i;
      exe_addr_q   <= rd_addr;
      byp_data_q   <= new_word;
    end
    if (exe_fire) begin
      gross_q   <= counted ? gross : 32'd0;
      counted_q <= counted;
      outside_q <= ((exe_kind_q == obl_pkg::KIND_SET) ||
                    (exe_kind_q == obl_pkg::KIND_DEL)) && !exe_in_win_q;
      ready_q   <= valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gross_change_o   = gross_q;
  assign counted_o        = counted_q;
  assign outside_window_o = outside_q;
  assign book_ready_o     = ready_q;

endmodule
